FILE: hw/rtl/lbct_pkg.sv
// Shared types and constants for the LRU block cache tag directory.
package lbct_pkg;

  localparam int KEY_W      = 64;
  localparam int LINE_IDX_W = 4;
  localparam int COUNT_W    = 32;
  localparam int CFG_W      = 5;

  localparam logic [CFG_W-1:0] LINES_IN_USE_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_INVALID  = 3'd2,
    ST_INSERTED = 3'd3,
    ST_UPDATED  = 3'd4,
    ST_REPLACED = 3'd5
  } status_t;

  // Flags of the search token that walks down the row of cells.
  typedef struct packed {
    logic live;
    logic found;
    logic have_vict;
  } token_t;

  // Broadcast update applied to all cells at the end of a search.
  typedef struct packed {
    logic en;
    logic write_tags;
    logic age_all;
  } update_t;

endpackage

FILE: hw/rtl/lbct_cell.sv
// One directory line: key tags, valid bit, recency rank and one search token stage.
module lbct_cell #(
  parameter int IDX_W = 4,
  parameter int INDEX = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       usable,
  input  logic [lbct_pkg::KEY_W-1:0] key_node,
  input  logic [lbct_pkg::KEY_W-1:0] key_block,
  input  lbct_pkg::token_t           tok_in,
  input  logic [IDX_W-1:0]           found_idx_in,
  input  logic [IDX_W-1:0]           found_rank_in,
  input  logic [IDX_W-1:0]           vict_idx_in,
  input  logic [IDX_W-1:0]           vict_rank_in,
  output lbct_pkg::token_t           tok_out,
  output logic [IDX_W-1:0]           found_idx_out,
  output logic [IDX_W-1:0]           found_rank_out,
  output logic [IDX_W-1:0]           vict_idx_out,
  output logic [IDX_W-1:0]           vict_rank_out,
  input  lbct_pkg::update_t          upd,
  input  logic [IDX_W-1:0]           upd_idx,
  input  logic [IDX_W-1:0]           upd_limit
);
  import lbct_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [KEY_W-1:0] node_tag;
  logic [KEY_W-1:0] block_tag;
  logic             valid;
  logic [IDX_W-1:0] rank;

  logic             hit_here;
  logic             take_vict;
  token_t           tok_next;
  logic [IDX_W-1:0] found_idx_next;
  logic [IDX_W-1:0] found_rank_next;
  logic [IDX_W-1:0] vict_idx_next;
  logic [IDX_W-1:0] vict_rank_next;

  always_comb begin
    hit_here  = usable && valid && (node_tag == key_node) && (block_tag == key_block);
    // The first usable valid line takes the victim slot; later ones only if strictly older.
    take_vict = usable && valid && (!tok_in.have_vict || (rank > vict_rank_in));

    tok_next.live      = tok_in.live;
    tok_next.found     = tok_in.found || hit_here;
    tok_next.have_vict = tok_in.have_vict || take_vict;

    found_idx_next  = found_idx_in;
    found_rank_next = found_rank_in;
    if (!tok_in.found && hit_here) begin
      found_idx_next  = MY_IDX;
      found_rank_next = rank;
    end

    vict_idx_next  = vict_idx_in;
    vict_rank_next = vict_rank_in;
    if (take_vict) begin
      vict_idx_next  = MY_IDX;
      vict_rank_next = rank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    found_idx_out  <= found_idx_next;
    found_rank_out <= found_rank_next;
    vict_idx_out   <= vict_idx_next;
    vict_rank_out  <= vict_rank_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (upd.en && upd.write_tags && (upd_idx == MY_IDX)) begin
      valid <= 1'b1;
    end
  end

  // Promoted line gets rank zero; valid lines newer than it (all on age_all) age by one.
  always_ff @(posedge clk) begin
    if (upd.en) begin
      if (upd_idx == MY_IDX) begin
        rank <= '0;
        if (upd.write_tags) begin
          node_tag  <= key_node;
          block_tag <= key_block;
        end
      end else if (valid && (upd.age_all || (rank < upd_limit))) begin
        rank <= rank + 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/lru_block_cache_tags_unit.sv
// Top level of the fully associative LRU tag directory: request control, decision, counters.
//
// Channel   Direction  Handshake         Payload
// request   in         start / busy      command, node_id, block_id
// result    out        done (one cycle)  status, line_index, query_count, hit_count
// config    in         cfg_we            cfg_data (lines_in_use)
//
// A search token walks the row of LINES cells one cell per cycle, starting in the cycle
// after acceptance, then the decision and the rank update happen at one edge, at which
// done is registered high. busy drops in the cycle done is high, so the next request can
// be accepted at the edge that ends it; no new request is taken while one is in flight.
// The result cannot be stalled. Reset clears all lines to invalid, the counters to zero
// and lines_in_use to 16.
module lru_block_cache_tags_unit #(
  parameter int LINES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            command,
  input  logic [lbct_pkg::KEY_W-1:0]      node_id,
  input  logic [lbct_pkg::KEY_W-1:0]      block_id,
  output logic                            done,
  output logic [2:0]                      status,
  output logic [lbct_pkg::LINE_IDX_W-1:0] line_index,
  output logic [lbct_pkg::COUNT_W-1:0]    query_count,
  output logic [lbct_pkg::COUNT_W-1:0]    hit_count,
  input  logic                            cfg_we,
  input  logic [lbct_pkg::CFG_W-1:0]      cfg_data
);
  import lbct_pkg::*;

  localparam int IDX_W  = $clog2(LINES);
  localparam int FILL_W = $clog2(LINES + 1);
  localparam int CNT_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;

  logic [CFG_W-1:0]   lines_in_use;
  logic [FILL_W-1:0]  lines_filled;
  logic [COUNT_W-1:0] queries_seen;
  logic [COUNT_W-1:0] hits_seen;

  logic               req_cmd;
  logic [KEY_W-1:0]   req_node;
  logic [KEY_W-1:0]   req_block;
  logic               inject;
  logic               accept;

  status_t            status_q;
  status_t            status_next;
  logic [IDX_W-1:0]   line_q;
  logic [IDX_W-1:0]   line_next;

  logic [CNT_W-1:0]   usable_count;
  logic [LINES-1:0]   usable;

  token_t             tok       [LINES+1];
  logic [IDX_W-1:0]   found_idx [LINES+1];
  logic [IDX_W-1:0]   found_rank[LINES+1];
  logic [IDX_W-1:0]   vict_idx  [LINES+1];
  logic [IDX_W-1:0]   vict_rank [LINES+1];

  update_t            upd;
  logic [IDX_W-1:0]   upd_idx;
  logic [IDX_W-1:0]   upd_limit;
  logic               query_inc;
  logic               hit_inc;
  logic               fill_inc;
  token_t             tok_end;
  logic               key_zero;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      lines_in_use <= LINES_IN_USE_RESET;
    end else if (cfg_we) begin
      lines_in_use <= cfg_data;
    end
  end

  always_comb begin
    if (lines_in_use == '0) begin
      usable_count = CNT_W'(1);
    end else if (CNT_W'(lines_in_use) > CNT_W'(LINES)) begin
      usable_count = CNT_W'(LINES);
    end else begin
      usable_count = CNT_W'(lines_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd   <= command;
      req_node  <= node_id;
      req_block <= block_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inject <= 1'b0;
      busy   <= 1'b0;
    end else begin
      inject <= accept;
      if (accept) begin
        busy <= 1'b1;
      end else if (tok_end.live) begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    tok[0]        = '0;
    tok[0].live   = inject;
    found_idx[0]  = '0;
    found_rank[0] = '0;
    vict_idx[0]   = '0;
    vict_rank[0]  = '0;
  end

  for (genvar i = 0; i < LINES; i++) begin : g_cell
    assign usable[i] = CNT_W'(i) < usable_count;

    lbct_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .usable         (usable[i]),
      .key_node       (req_node),
      .key_block      (req_block),
      .tok_in         (tok[i]),
      .found_idx_in   (found_idx[i]),
      .found_rank_in  (found_rank[i]),
      .vict_idx_in    (vict_idx[i]),
      .vict_rank_in   (vict_rank[i]),
      .tok_out        (tok[i+1]),
      .found_idx_out  (found_idx[i+1]),
      .found_rank_out (found_rank[i+1]),
      .vict_idx_out   (vict_idx[i+1]),
      .vict_rank_out  (vict_rank[i+1]),
      .upd            (upd),
      .upd_idx        (upd_idx),
      .upd_limit      (upd_limit)
    );
  end

  assign tok_end  = tok[LINES];
  assign key_zero = (req_node == '0) && (req_block == '0);

  // Decision on the finished token; the update reaches every cell at the same edge.
  always_comb begin
    status_next = ST_MISS;
    line_next   = '0;
    upd         = '0;
    upd_idx     = '0;
    upd_limit   = '0;
    query_inc   = 1'b0;
    hit_inc     = 1'b0;
    fill_inc    = 1'b0;
    if (tok_end.live) begin
      if (req_cmd == CMD_GET) begin
        query_inc = 1'b1;
        if (key_zero) begin
          status_next = ST_INVALID;
        end else if (tok_end.found) begin
          status_next = ST_HIT;
          line_next   = found_idx[LINES];
          hit_inc     = 1'b1;
          upd.en      = 1'b1;
          upd_idx     = found_idx[LINES];
          upd_limit   = found_rank[LINES];
        end
      end else if (tok_end.found) begin
        status_next = ST_UPDATED;
        line_next   = found_idx[LINES];
      end else if (CNT_W'(lines_filled) < usable_count) begin
        status_next    = ST_INSERTED;
        line_next      = lines_filled[IDX_W-1:0];
        fill_inc       = 1'b1;
        upd.en         = 1'b1;
        upd.write_tags = 1'b1;
        upd.age_all    = 1'b1;
        upd_idx        = lines_filled[IDX_W-1:0];
      end else begin
        status_next    = ST_REPLACED;
        line_next      = vict_idx[LINES];
        upd.en         = 1'b1;
        upd.write_tags = 1'b1;
        upd.age_all    = !tok_end.have_vict;
        upd_idx        = vict_idx[LINES];
        upd_limit      = vict_rank[LINES];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lines_filled <= '0;
      queries_seen <= '0;
      hits_seen    <= '0;
      done         <= 1'b0;
    end else begin
      done <= tok_end.live;
      if (fill_inc) begin
        lines_filled <= lines_filled + 1'b1;
      end
      if (query_inc) begin
        queries_seen <= queries_seen + 1'b1;
      end
      if (hit_inc) begin
        hits_seen <= hits_seen + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_end.live) begin
      status_q <= status_next;
      line_q   <= line_next;
    end
  end

  assign status      = status_q;
  assign line_index  = LINE_IDX_W'(line_q);
  assign query_count = queries_seen;
  assign hit_count   = hits_seen;

endmodule
